/* src/zcfm_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// zcfm_pkg
// Shared types, constants and helpers for the zero-crossing flutter meter.
// ============================================================================
package zcfm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int PERIOD_W   = 28;
    localparam int NOMINAL_W  = 32;
    localparam int LIMIT_W    = 15;
    localparam int ACC_W      = 40;
    localparam int DIVIDEND_W = SAMPLE_W + PERIOD_W;
    localparam int CNT_W      = 32;
    localparam int SUM_W      = 48;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // one quotient bit per divide step
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = 28'd5333333;
    localparam logic [NOMINAL_W-1:0] NOMINAL_RESET = 32'd40634921;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 15'd600;
    localparam logic [CNT_W-1:0]     MIN_RESET     = 32'd2000000;

    localparam logic [SAMPLE_W-1:0]  ERR_POS_MAX   = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0]  ERR_NEG_MAG   = 16'h8000;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_DIVIDE,
        ST_DIV_END,
        ST_DIFF,
        ST_SCALE,
        ST_SQUARE,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic load_sample;
        logic commit;
        logic start_div;
        logic div_step;
        logic div_end;
        logic add_period;
        logic diff;
        logic scale;
        logic square;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic primed;
        logic sign_change;
        logic cur_zero;
    } t_dp_status;

    function automatic logic [SAMPLE_W-1:0] abs16(input logic signed [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] r;
        r = v[SAMPLE_W-1] ? SAMPLE_W'(-v) : SAMPLE_W'(v);
        return r;
    endfunction

endpackage

/* src/zero_crossing_flutter_meter_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// zero_crossing_flutter_meter_core
// Wow and flutter meter: half periods of a test tone from zero crossings.
// ============================================================================
// A sample without a crossing passes classify and returns to idle before
// the next sample is taken. A zero sample then passes diff, scale, square
// and update; a sign change first runs the 44-step restoring divider that
// places the crossing by linear interpolation, one quotient bit per cycle.
// A finished result sits in an output register, so the next sample is taken
// while it waits; a following result waits in its last step until the
// previous one has been taken. The first sample after reset only primes the
// last-sample register. Configuration writes belong to idle periods.
module zero_crossing_flutter_meter_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [zcfm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [zcfm_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [zcfm_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [zcfm_pkg::CNT_W-1:0]             o_interval_ns,
    output logic signed [zcfm_pkg::SAMPLE_W-1:0]   o_error_tenths,
    output logic                                   o_in_range,
    output logic [zcfm_pkg::CNT_W-1:0]             o_max_interval,
    output logic [zcfm_pkg::CNT_W-1:0]             o_min_interval,
    output logic [zcfm_pkg::CNT_W-1:0]             o_accepted_count,
    output logic [zcfm_pkg::CNT_W-1:0]             o_crossing_count,
    output logic [zcfm_pkg::SUM_W-1:0]             o_squared_error_sum,
    output logic [zcfm_pkg::SUM_W-1:0]             o_interval_total
);

    zcfm_pkg::t_dp_cmd    w_cmd;
    zcfm_pkg::t_dp_status w_status;

    zcfm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    zcfm_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_sample            (i_sample),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .o_interval_ns       (o_interval_ns),
        .o_error_tenths      (o_error_tenths),
        .o_in_range          (o_in_range),
        .o_max_interval      (o_max_interval),
        .o_min_interval      (o_min_interval),
        .o_accepted_count    (o_accepted_count),
        .o_crossing_count    (o_crossing_count),
        .o_squared_error_sum (o_squared_error_sum),
        .o_interval_total    (o_interval_total)
    );

endmodule

/* src/zcfm_ctrl.sv */
`timescale 1ns / 1ps
// ============================================================================
// zcfm_ctrl
// Sequencer: handshakes, divide step count and datapath commands.
// ============================================================================
module zcfm_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  zcfm_pkg::t_dp_status  i_status,
    output zcfm_pkg::t_dp_cmd     o_cmd
);

    zcfm_pkg::t_state r_state, n_state;
    logic [zcfm_pkg::DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic r_out_valid, n_out_valid;
    logic w_out_free;
    logic w_div_last;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_div_last = (r_div_cnt == zcfm_pkg::DIV_CNT_W'(zcfm_pkg::DIV_STEPS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            zcfm_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = zcfm_pkg::ST_CLASSIFY;
            end
            zcfm_pkg::ST_CLASSIFY: begin
                if (!i_status.primed)          n_state = zcfm_pkg::ST_IDLE;
                else if (i_status.sign_change) n_state = zcfm_pkg::ST_DIVIDE;
                else if (i_status.cur_zero)    n_state = zcfm_pkg::ST_DIFF;
                else                           n_state = zcfm_pkg::ST_IDLE;
            end
            zcfm_pkg::ST_DIVIDE: begin
                if (w_div_last) n_state = zcfm_pkg::ST_DIV_END;
            end
            zcfm_pkg::ST_DIV_END: n_state = zcfm_pkg::ST_DIFF;
            zcfm_pkg::ST_DIFF:    n_state = zcfm_pkg::ST_SCALE;
            zcfm_pkg::ST_SCALE:   n_state = zcfm_pkg::ST_SQUARE;
            zcfm_pkg::ST_SQUARE:  n_state = zcfm_pkg::ST_UPDATE;
            zcfm_pkg::ST_UPDATE: begin
                if (w_out_free) n_state = zcfm_pkg::ST_IDLE;
            end
            default: n_state = zcfm_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        n_div_cnt   = '0;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            zcfm_pkg::ST_IDLE: begin
                o_cmd.load_sample = i_in_valid;
            end
            zcfm_pkg::ST_CLASSIFY: begin
                o_cmd.commit     = 1'b1;
                o_cmd.start_div  = i_status.primed && i_status.sign_change;
                o_cmd.add_period = i_status.primed && !i_status.sign_change;
            end
            zcfm_pkg::ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = w_div_last ? '0 : r_div_cnt + 1'b1;
            end
            zcfm_pkg::ST_DIV_END: o_cmd.div_end = 1'b1;
            zcfm_pkg::ST_DIFF:    o_cmd.diff    = 1'b1;
            zcfm_pkg::ST_SCALE:   o_cmd.scale   = 1'b1;
            zcfm_pkg::ST_SQUARE:  o_cmd.square  = 1'b1;
            zcfm_pkg::ST_UPDATE: begin
                if (w_out_free) begin
                    o_cmd.update = 1'b1;
                    n_out_valid  = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= zcfm_pkg::ST_IDLE;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != zcfm_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_div_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == zcfm_pkg::ST_DIVIDE |-> r_div_cnt <= zcfm_pkg::DIV_CNT_W'(zcfm_pkg::DIV_STEPS - 1))
        else $error("divide count out of range");

    a_div_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == zcfm_pkg::ST_DIVIDE && !w_div_last |=> r_state == zcfm_pkg::ST_DIVIDE)
        else $error("divider left early");

    a_update_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == zcfm_pkg::ST_UPDATE && r_out_valid && i_out_stall
        |=> r_state == zcfm_pkg::ST_UPDATE && r_out_valid)
        else $error("result overwritten while pending");

    a_cnt_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != zcfm_pkg::ST_DIVIDE |-> r_div_cnt == '0)
        else $error("divide count not cleared");
`endif

endmodule

/* src/zcfm_datapath.sv */
`timescale 1ns / 1ps
// ============================================================================
// zcfm_datapath
// Registers, interpolation divider, error scaling and running statistics.
// ============================================================================
module zcfm_datapath (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_cfg_we,
    input  logic [zcfm_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [zcfm_pkg::CFG_DATA_W-1:0]            i_cfg_data,
    input  logic signed [zcfm_pkg::SAMPLE_W-1:0]       i_sample,
    input  zcfm_pkg::t_dp_cmd                          i_cmd,
    output zcfm_pkg::t_dp_status                       o_status,
    output logic [zcfm_pkg::CNT_W-1:0]                 o_interval_ns,
    output logic signed [zcfm_pkg::SAMPLE_W-1:0]       o_error_tenths,
    output logic                                       o_in_range,
    output logic [zcfm_pkg::CNT_W-1:0]                 o_max_interval,
    output logic [zcfm_pkg::CNT_W-1:0]                 o_min_interval,
    output logic [zcfm_pkg::CNT_W-1:0]                 o_accepted_count,
    output logic [zcfm_pkg::CNT_W-1:0]                 o_crossing_count,
    output logic [zcfm_pkg::SUM_W-1:0]                 o_squared_error_sum,
    output logic [zcfm_pkg::SUM_W-1:0]                 o_interval_total
);

    localparam int SW = zcfm_pkg::SAMPLE_W;
    localparam int PW = zcfm_pkg::PERIOD_W;
    localparam int AW = zcfm_pkg::ACC_W;
    localparam int DW = zcfm_pkg::DIVIDEND_W;
    localparam int CW = zcfm_pkg::CNT_W;
    localparam int MW = DW - 8;
    localparam int QW = 2 * SW;

    // configuration
    logic [PW-1:0]                      r_period;
    logic [zcfm_pkg::NOMINAL_W-1:0]     r_nominal;
    logic [zcfm_pkg::LIMIT_W-1:0]       r_limit;

    // sample tracking
    logic signed [SW-1:0] r_cur, r_prev;
    logic                 r_primed;
    logic [AW-1:0]        r_acc;
    logic [PW-1:0]        r_next_acc;

    // divider
    logic [DW-1:0] r_quo;
    logic [SW-1:0] r_rem, r_divisor;

    // error path
    logic          r_neg;
    logic [AW-1:0] r_diff;
    logic [SW-1:0] r_emag;
    logic signed [SW-1:0] r_err;
    logic          r_ok;
    logic [QW-1:0] r_sq;

    // statistics and result
    logic [CW-1:0] r_max, r_min, r_good, r_all;
    logic [zcfm_pkg::SUM_W-1:0] r_sqsum, r_total;
    logic [CW-1:0] r_out_ns;
    logic signed [SW-1:0] r_out_err;
    logic r_out_ok;

    logic [SW-1:0] w_a, w_b;
    logic [DW-1:0] w_product;
    logic [SW:0]   w_rem_shift, w_rem_sub;
    logic          w_ge;
    logic [PW-1:0] w_d;
    logic [AW:0]   w_acc_plus;
    logic [AW-1:0] w_nom40;
    logic [DW-1:0] w_mag44;
    logic [MW-1:0] w_mag;
    logic [SW-1:0] w_emag;
    logic [CW-1:0] w_ns;
    logic [zcfm_pkg::SUM_W:0] w_sq_plus, w_tot_plus;

    assign w_a = zcfm_pkg::abs16(r_prev);
    assign w_b = zcfm_pkg::abs16(r_cur);

    assign o_status.primed      = r_primed;
    assign o_status.cur_zero    = (r_cur == '0);
    assign o_status.sign_change = (r_cur != '0) && (r_prev != '0)
                                  && (r_cur[SW-1] != r_prev[SW-1]);

    assign w_product = DW'(w_a) * DW'(r_period);

    // restoring divide, one quotient bit per cycle
    assign w_rem_shift = {r_rem, r_quo[DW-1]};
    assign w_ge        = (w_rem_shift >= {1'b0, r_divisor});
    assign w_rem_sub   = w_rem_shift - {1'b0, r_divisor};

    // quotient never exceeds the period since a <= a + b
    assign w_d = r_quo[PW-1:0];

    assign w_acc_plus = {1'b0, r_acc} + (i_cmd.div_end ? (AW+1)'(w_d) : (AW+1)'(r_period));

    assign w_nom40 = AW'(r_nominal);
    // diff * 10 / 256
    assign w_mag44 = DW'({r_diff, 3'b000}) + DW'({r_diff, 1'b0});
    assign w_mag   = w_mag44[DW-1:8];

    always_comb begin
        if (r_neg)
            w_emag = (w_mag > MW'(zcfm_pkg::ERR_NEG_MAG)) ? zcfm_pkg::ERR_NEG_MAG : w_mag[SW-1:0];
        else
            w_emag = (w_mag > MW'(zcfm_pkg::ERR_POS_MAX)) ? zcfm_pkg::ERR_POS_MAX : w_mag[SW-1:0];
    end

    assign w_ns       = r_acc[AW-1:8];
    assign w_sq_plus  = {1'b0, r_sqsum} + (zcfm_pkg::SUM_W+1)'(r_sq);
    assign w_tot_plus = {1'b0, r_total} + (zcfm_pkg::SUM_W+1)'(w_ns);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= zcfm_pkg::PERIOD_RESET;
            r_nominal <= zcfm_pkg::NOMINAL_RESET;
            r_limit   <= zcfm_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                zcfm_pkg::CFG_SAMPLE_PERIOD: r_period  <= i_cfg_data[PW-1:0];
                zcfm_pkg::CFG_NOMINAL:       r_nominal <= i_cfg_data[zcfm_pkg::NOMINAL_W-1:0];
                zcfm_pkg::CFG_ERROR_LIMIT:   r_limit   <= i_cfg_data[zcfm_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_primed <= 1'b0;
            r_acc    <= '0;
            r_max    <= '0;
            r_min    <= zcfm_pkg::MIN_RESET;
            r_good   <= '0;
            r_all    <= '0;
            r_sqsum  <= '0;
            r_total  <= '0;
        end else begin
            if (i_cmd.commit) begin
                r_prev   <= r_cur;
                r_primed <= 1'b1;
            end
            if (i_cmd.add_period || i_cmd.div_end)
                r_acc <= w_acc_plus[AW] ? '1 : w_acc_plus[AW-1:0];
            if (i_cmd.update) begin
                r_acc <= AW'(r_next_acc);
                if (r_ok) begin
                    r_sqsum <= w_sq_plus[zcfm_pkg::SUM_W] ? '1 : w_sq_plus[zcfm_pkg::SUM_W-1:0];
                    r_good  <= (r_good == '1) ? r_good : r_good + 1'b1;
                    if (w_ns > r_max) r_max <= w_ns;
                    if (w_ns < r_min) r_min <= w_ns;
                end
                r_total <= w_tot_plus[zcfm_pkg::SUM_W] ? '1 : w_tot_plus[zcfm_pkg::SUM_W-1:0];
                r_all   <= (r_all == '1) ? r_all : r_all + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) r_cur <= i_sample;
        if (i_cmd.add_period)  r_next_acc <= '0;
        if (i_cmd.start_div) begin
            r_quo     <= w_product;
            r_rem     <= '0;
            r_divisor <= w_a + w_b;
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[DW-2:0], w_ge};
            r_rem <= w_ge ? w_rem_sub[SW-1:0] : w_rem_shift[SW-1:0];
        end
        if (i_cmd.div_end) r_next_acc <= r_period - w_d;
        if (i_cmd.diff) begin
            r_neg  <= (r_acc > w_nom40);
            r_diff <= (r_acc > w_nom40) ? r_acc - w_nom40 : w_nom40 - r_acc;
        end
        if (i_cmd.scale) begin
            r_emag <= w_emag;
            r_err  <= r_neg ? signed'(SW'(-w_emag)) : signed'(w_emag);
            r_ok   <= (w_emag < SW'(r_limit));
        end
        if (i_cmd.square) r_sq <= QW'(r_emag) * QW'(r_emag);
        if (i_cmd.update) begin
            r_out_ns  <= w_ns;
            r_out_err <= r_err;
            r_out_ok  <= r_ok;
        end
    end

    assign o_interval_ns       = r_out_ns;
    assign o_error_tenths      = r_out_err;
    assign o_in_range          = r_out_ok;
    assign o_max_interval      = r_max;
    assign o_min_interval      = r_min;
    assign o_accepted_count    = r_good;
    assign o_crossing_count    = r_all;
    assign o_squared_error_sum = r_sqsum;
    assign o_interval_total    = r_total;

endmodule
